/* rtl/assert_macros.svh */
// assertion macros used by the deframer core
// expects a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tdcdf_pkg.sv */
// types, constants and the per-byte record parser step for the tdc hit bank deframer
// no dependencies
`default_nettype none

package tdcdf_pkg;

  localparam int WORD_W    = 32;
  localparam int CRATE_W   = 17;
  localparam int SLOTOFF_W = 9;
  localparam int SLOT_W    = 10;
  localparam int CHAN_W    = 7;
  localparam int TDC_W     = 15;
  localparam int HIT_W     = CRATE_W + SLOT_W + CHAN_W + TDC_W;
  localparam int TDATA_W   = ((HIT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CRATE_TAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_OFFSET = 2'd1;

  localparam logic [CRATE_W-1:0] CRATE_TAG_RESET = 17'h1FFFF;

  // record byte positions
  localparam logic [4:0] IDX_SLOT = 5'd0;
  localparam logic [4:0] IDX_CNT0 = 5'd13;
  localparam logic [4:0] IDX_CNT1 = 5'd14;
  localparam logic [4:0] IDX_CNT2 = 5'd15;
  localparam logic [4:0] IDX_CNT3 = 5'd16;
  localparam logic [4:0] IDX_CHAN = 5'd17;
  localparam logic [4:0] IDX_TLO  = 5'd18;
  localparam logic [4:0] IDX_THI  = 5'd19;

  localparam logic [33:0] REC_HDR_BYTES = 34'd17;
  localparam logic [33:0] HIT_BYTES     = 34'd3;

  typedef enum logic [2:0] {
    PH_FMT_HDR  = 3'd0,
    PH_FMT_SKIP = 3'd1,
    PH_DLEN     = 3'd2,
    PH_HDR2     = 3'd3,
    PH_DATA     = 3'd4,
    PH_IDLE     = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] fmt_left;
    logic [31:0] dlen;
    logic [33:0] dbytes;
    logic [4:0]  ridx;
    logic [31:0] hits;
    logic [7:0]  slot;
    logic [23:0] count;
    logic [7:0]  chan;
    logic [7:0]  tlo;
  } parse_t;

  // first member sits in the high bits, so crate lands lowest
  typedef struct packed {
    logic        [TDC_W-1:0]   tdc;
    logic        [CHAN_W-1:0]  channel;
    logic signed [SLOT_W-1:0]  slot;
    logic signed [CRATE_W-1:0] crate;
  } hit_t;

  typedef struct packed {
    logic [1:0] n;
    hit_t       h0;
    hit_t       h1;
  } hits_t;

  typedef struct packed {
    parse_t      s;
    logic        hv;
    logic [15:0] raw;
  } byte_res_t;

  function automatic byte_res_t take_byte(parse_t s, logic [7:0] b);
    byte_res_t   r;
    logic [31:0] n;
    r     = '{s: s, hv: 1'b0, raw: 16'd0};
    n     = {b, s.count};
    if (s.phase == PH_DATA) begin
      if (r.s.ridx == IDX_CHAN && r.s.hits == 32'd0) begin
        r.s.ridx = IDX_SLOT;
      end
      if (r.s.ridx == IDX_SLOT && r.s.dbytes < REC_HDR_BYTES) begin
        r.s.phase = PH_IDLE;
      end else if (r.s.ridx == IDX_CHAN && r.s.dbytes < HIT_BYTES) begin
        r.s.phase = PH_IDLE;
      end else begin
        r.s.dbytes = r.s.dbytes - 34'd1;
        if (r.s.ridx == IDX_SLOT) begin
          r.s.slot = b;
          r.s.ridx = 5'd1;
        end else if (r.s.ridx < IDX_CNT0) begin
          r.s.ridx = r.s.ridx + 5'd1;
        end else if (r.s.ridx < IDX_CNT3) begin
          // count bytes start cleared, so plain assignment matches or-in
          case (r.s.ridx)
            IDX_CNT0: r.s.count[7:0]   = b;
            IDX_CNT1: r.s.count[15:8]  = b;
            default:  r.s.count[23:16] = b;
          endcase
          r.s.ridx = r.s.ridx + 5'd1;
        end else if (r.s.ridx == IDX_CNT3) begin
          r.s.hits  = n[31] ? 32'd0 : n;
          r.s.count = 24'd0;
          r.s.ridx  = IDX_CHAN;
        end else if (r.s.ridx == IDX_CHAN) begin
          r.s.chan = b;
          r.s.ridx = IDX_TLO;
        end else if (r.s.ridx == IDX_TLO) begin
          r.s.tlo  = b;
          r.s.ridx = IDX_THI;
        end else begin
          r.raw    = {b, r.s.tlo};
          r.hv     = 1'b1;
          r.s.hits = r.s.hits - 32'd1;
          r.s.ridx = IDX_CHAN;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tdc_hit_bank_deframer_core.sv */
// Deframes a packed tdc hit bank arriving one 32-bit word per transfer, low byte first,
// and emits one result per hit (crate, slot, channel, tdc) with tlast on the final hit
// of each word. A word is registered at the input and parsed from that register into a
// result register that holds up to two hits. A new word is taken every cycle while the
// result side accepts and words give at most one hit; a word giving two hits holds the
// input until its second hit leaves, set by the single result port. Configuration
// writes (index 0 crate tag, index 1 slot offset) belong between buffers, with the block
// idle. Depends on tdcdf_pkg, tdcdf_parser and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tdc_hit_bank_deframer_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [tdcdf_pkg::WORD_W-1:0]      s_tdata,   // word
  input  wire logic                              s_tlast,   // last_word
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [tdcdf_pkg::TDATA_W-1:0]          m_tdata,   // crate, slot, channel, tdc
  output logic                                   m_tlast,   // last hit of the word
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tdcdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tdcdf_pkg::CRATE_W-1:0]     cfg_data
);
  import tdcdf_pkg::*;

  logic [CRATE_W-1:0]   crate_tag;
  logic [SLOTOFF_W-1:0] slot_offset;

  logic              iv;
  logic [WORD_W-1:0] iword;
  logic              ilast;

  logic  pv;
  logic  pcnt2;
  logic  psel;
  hit_t  p0;
  hit_t  p1;
  hits_t hits;

  logic pop_final;
  logic pair_free;
  logic process;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crate_tag   <= CRATE_TAG_RESET;
      slot_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CRATE_TAG:   crate_tag   <= cfg_data;
        CFG_SLOT_OFFSET: slot_offset <= cfg_data[SLOTOFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // final hit of the held pair leaves this cycle
  assign pop_final = pv && m_tready && (psel || !pcnt2);
  assign pair_free = !pv || pop_final;
  assign process   = iv && pair_free;
  assign s_tready  = !iv || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tready) begin
      iv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      iword <= s_tdata;
      ilast <= s_tlast;
    end
  end

  tdcdf_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (process),
    .word        (iword),
    .last_word   (ilast),
    .crate_tag   (crate_tag),
    .slot_offset (slot_offset),
    .hits        (hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pv    <= 1'b0;
      pcnt2 <= 1'b0;
      psel  <= 1'b0;
    end else if (process) begin
      pv    <= (hits.n != 2'd0);
      pcnt2 <= (hits.n == 2'd2);
      psel  <= 1'b0;
    end else if (pop_final) begin
      pv   <= 1'b0;
      psel <= 1'b0;
    end else if (pv && m_tready) begin
      psel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      p0 <= hits.h0;
      p1 <= hits.h1;
    end
  end

  assign m_tvalid = pv;
  assign m_tdata  = {{(TDATA_W-HIT_W){1'b0}}, (psel ? p1 : p0)};
  assign m_tlast  = psel || !pcnt2;

  `ASSERT_IMP(a_second_hit_only_in_pair, pv && psel, pcnt2, "second hit shown without a pair")
  `ASSERT_NXT(a_hits_load_result, process && hits.n != 2'd0, pv && !psel,
              "parsed hits did not reach the result register")
  `ASSERT_NXT(a_stall_holds_select, pv && !m_tready, pv && $stable(psel),
              "result selection moved while stalled")

endmodule

`default_nettype wire

/* rtl/tdcdf_parser.sv */
// word-level deframer state machine with the record parse of four bytes per word
// depends on tdcdf_pkg
`default_nettype none

module tdcdf_parser (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step,
  input  wire logic [tdcdf_pkg::WORD_W-1:0]      word,
  input  wire logic                              last_word,
  input  wire logic [tdcdf_pkg::CRATE_W-1:0]     crate_tag,
  input  wire logic [tdcdf_pkg::SLOTOFF_W-1:0]   slot_offset,
  output tdcdf_pkg::hits_t                       hits
);
  import tdcdf_pkg::*;

  parse_t      st;
  parse_t      st_next;
  parse_t      cur;
  byte_res_t   br;
  hit_t        h;
  logic [33:0] total;
  logic [33:0] pad;
  logic [15:0] fmt_dec;

  always_comb begin
    cur     = st;
    hits    = '0;
    br      = '0;
    h       = '0;
    total   = {st.dlen - 32'd1, 2'b00};
    pad     = {32'd0, word[15:14]};
    fmt_dec = st.fmt_left - 16'd1;
    unique case (st.phase)
      PH_FMT_HDR: begin
        cur.fmt_left = word[15:0];
        cur.phase    = (word[15:0] != 16'd0) ? PH_FMT_SKIP : PH_DLEN;
      end
      PH_FMT_SKIP: begin
        cur.fmt_left = fmt_dec;
        if (fmt_dec == 16'd0) begin
          cur.phase = PH_DLEN;
        end
      end
      PH_DLEN: begin
        cur.dlen  = word;
        cur.phase = PH_HDR2;
      end
      PH_HDR2: begin
        if (st.dlen == 32'd0 || total <= pad) begin
          cur.phase = PH_IDLE;
        end else begin
          cur.dbytes = total - pad;
          cur.ridx   = IDX_SLOT;
          cur.hits   = 32'd0;
          cur.count  = 24'd0;
          cur.phase  = PH_DATA;
        end
      end
      PH_DATA: begin
        for (int k = 0; k < 4; k++) begin
          br  = take_byte(cur, word[8*k +: 8]);
          cur = br.s;
          h.crate   = crate_tag;
          h.slot    = {{2{br.s.slot[7]}}, br.s.slot}
                    + {slot_offset[SLOTOFF_W-1], slot_offset};
          h.channel = {br.s.chan[5:0], br.raw[15]};
          h.tdc     = br.raw[14:0];
          if (br.hv) begin
            if (hits.n == 2'd0) begin
              hits.h0 = h;
            end else begin
              hits.h1 = h;
            end
            hits.n = hits.n + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
    st_next = last_word ? parse_t'('0) : cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire
